// File: hdl/tlv_frame_deframer_checksum_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TLV_FRAME_DEFRAMER_CHECKSUM_MACROS_SVH
`define TLV_FRAME_DEFRAMER_CHECKSUM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tlvd_pkg.sv
// Shared types and constants of the TLV frame deframer.
// No dependencies; used by tlvd_parse, tlvd_oreg and the top level.
package tlvd_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 1'b0,
    REG_HEADER_SECOND = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    K_START = 3'd0,
    K_VALUE = 3'd1,
    K_GOOD  = 3'd2,
    K_BAD   = 3'd3,
    K_MALF  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_type;
    logic [15:0] device_addr;
    logic [7:0]  frame_code;
    logic [15:0] param_length;
    logic [3:0]  tlv_index;
    logic [7:0]  tlv_type;
    logic [7:0]  tlv_length;
    logic [7:0]  value_index;
    logic [7:0]  value_byte;
  } res_t;

endpackage

// File: hdl/tlvd_parse.sv
// Frame parser: header hunt, frame fields, TLV walk, checksum, a byte per valid cycle.
// Depends on tlvd_pkg.
module tlvd_parse #(
  parameter int unsigned MAX_TLVS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tlvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       byte_vld,
  input  logic [7:0]                 byte_in,
  output logic                       res_vld,
  output tlvd_pkg::res_t             res
);
  import tlvd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TLVS + 1);

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_TYPE    = 4'd2,
    PH_ADDR_HI = 4'd3,
    PH_ADDR_LO = 4'd4,
    PH_CODE    = 4'd5,
    PH_LEN_HI  = 4'd6,
    PH_LEN_LO  = 4'd7,
    PH_TLV_T   = 4'd8,
    PH_TLV_L   = 4'd9,
    PH_VALUE   = 4'd10,
    PH_SKIP    = 4'd11,
    PH_CHECK   = 4'd12
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_first_r, hdr_second_r;
  logic [7:0]  sum_r, sum_nxt, sum_add;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] rem_r, rem_nxt, rem_dec;
  logic [7:0]  ttype_r, ttype_nxt;
  logic [7:0]  tlen_r, tlen_nxt;
  logic [7:0]  vpos_r, vpos_nxt, vpos_inc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_done;
  logic [CNT_W+3:0] cnt_ext;
  logic        cnt_lt;
  logic        malf_r, malf_nxt;
  logic        emit;
  kind_t       emit_kind;
  logic        emit_tlv;
  logic [7:0]  emit_vidx, emit_vbyte;

  assign sum_add  = sum_r + byte_in;
  assign rem_dec  = rem_r - 16'd1;
  assign vpos_inc = vpos_r + 8'd1;
  assign cnt_lt   = (cnt_r < CNT_W'(MAX_TLVS));
  assign cnt_done = cnt_lt ? cnt_r + CNT_W'(1) : cnt_r;
  assign cnt_ext  = {4'b0000, cnt_r};

  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    ftype_nxt  = ftype_r;
    addr_nxt   = addr_r;
    code_nxt   = code_r;
    plen_nxt   = plen_r;
    rem_nxt    = rem_r;
    ttype_nxt  = ttype_r;
    tlen_nxt   = tlen_r;
    vpos_nxt   = vpos_r;
    cnt_nxt    = cnt_r;
    malf_nxt   = malf_r;
    emit       = 1'b0;
    emit_kind  = K_GOOD;
    emit_tlv   = 1'b0;
    emit_vidx  = 8'd0;
    emit_vbyte = 8'd0;

    unique case (phase_r)
      PH_HUNT2: begin
        if (byte_in == hdr_second_r) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_TYPE;
        end else if (byte_in == hdr_first_r) begin
          sum_nxt = byte_in;
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_TYPE: begin
        sum_nxt   = sum_add;
        ftype_nxt = byte_in;
        phase_nxt = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        sum_nxt   = sum_add;
        addr_nxt  = {byte_in, 8'd0};
        phase_nxt = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        sum_nxt   = sum_add;
        addr_nxt  = {addr_r[15:8], byte_in};
        phase_nxt = PH_CODE;
      end
      PH_CODE: begin
        sum_nxt   = sum_add;
        code_nxt  = byte_in;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_nxt   = sum_add;
        plen_nxt  = {byte_in, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_nxt   = sum_add;
        plen_nxt  = {plen_r[15:8], byte_in};
        rem_nxt   = {plen_r[15:8], byte_in};
        cnt_nxt   = '0;
        malf_nxt  = 1'b0;
        ttype_nxt = 8'd0;
        tlen_nxt  = 8'd0;
        vpos_nxt  = 8'd0;
        phase_nxt = ({plen_r[15:8], byte_in} != 16'd0) ? PH_TLV_T : PH_CHECK;
      end
      PH_TLV_T: begin
        sum_nxt   = sum_add;
        ttype_nxt = byte_in;
        tlen_nxt  = 8'd0;
        vpos_nxt  = 8'd0;
        rem_nxt   = rem_dec;
        if (rem_dec == 16'd0) begin
          malf_nxt  = 1'b1;
          phase_nxt = PH_CHECK;
        end else begin
          phase_nxt = PH_TLV_L;
        end
      end
      PH_TLV_L: begin
        sum_nxt  = sum_add;
        tlen_nxt = byte_in;
        rem_nxt  = rem_dec;
        if ({8'd0, byte_in} > rem_dec) begin
          // Value would overrun the parameter area: swallow the rest silently.
          malf_nxt  = 1'b1;
          phase_nxt = (rem_dec != 16'd0) ? PH_SKIP : PH_CHECK;
        end else begin
          emit      = cnt_lt;
          emit_kind = K_START;
          emit_tlv  = 1'b1;
          vpos_nxt  = 8'd0;
          if (byte_in == 8'd0) begin
            cnt_nxt   = cnt_done;
            phase_nxt = (rem_dec != 16'd0) ? PH_TLV_T : PH_CHECK;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        sum_nxt    = sum_add;
        emit       = cnt_lt;
        emit_kind  = K_VALUE;
        emit_tlv   = 1'b1;
        emit_vidx  = vpos_r;
        emit_vbyte = byte_in;
        vpos_nxt   = vpos_inc;
        rem_nxt    = rem_dec;
        if (vpos_inc >= tlen_r || rem_dec == 16'd0) begin
          cnt_nxt   = cnt_done;
          phase_nxt = (rem_dec != 16'd0) ? PH_TLV_T : PH_CHECK;
        end
      end
      PH_SKIP: begin
        sum_nxt = sum_add;
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        sum_nxt = sum_add;
        emit    = 1'b1;
        if (sum_add != 8'd0) begin
          emit_kind = K_BAD;
        end else if (malf_r) begin
          emit_kind = K_MALF;
        end else begin
          emit_kind = K_GOOD;
        end
        phase_nxt = PH_HUNT1;
      end
      default: begin
        if (byte_in == hdr_first_r) begin
          sum_nxt   = byte_in;
          phase_nxt = PH_HUNT2;
        end else begin
          phase_nxt = PH_HUNT1;
        end
      end
    endcase
  end

  always_comb begin
    res_vld          = byte_vld && emit;
    res.kind         = emit_kind;
    res.frame_type   = ftype_r;
    res.device_addr  = addr_r;
    res.frame_code   = code_r;
    res.param_length = plen_r;
    res.tlv_index    = emit_tlv ? cnt_ext[3:0] : 4'd0;
    res.tlv_type     = emit_tlv ? ttype_r : 8'd0;
    res.tlv_length   = emit_tlv ? tlen_nxt : 8'd0;
    res.value_index  = emit_vidx;
    res.value_byte   = emit_vbyte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_r  <= 8'd0;
      hdr_second_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_FIRST:  hdr_first_r  <= cfg_data;
        REG_HEADER_SECOND: hdr_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      sum_r   <= 8'd0;
      ftype_r <= 8'd0;
      addr_r  <= 16'd0;
      code_r  <= 8'd0;
      plen_r  <= 16'd0;
      rem_r   <= 16'd0;
      ttype_r <= 8'd0;
      tlen_r  <= 8'd0;
      vpos_r  <= 8'd0;
      cnt_r   <= '0;
      malf_r  <= 1'b0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      ftype_r <= ftype_nxt;
      addr_r  <= addr_nxt;
      code_r  <= code_nxt;
      plen_r  <= plen_nxt;
      rem_r   <= rem_nxt;
      ttype_r <= ttype_nxt;
      tlen_r  <= tlen_nxt;
      vpos_r  <= vpos_nxt;
      cnt_r   <= cnt_nxt;
      malf_r  <= malf_nxt;
    end
  end

endmodule

// File: hdl/tlvd_oreg.sv
// Two-entry result stage: output register plus skid register.
// Depends on tlvd_pkg and tlv_frame_deframer_checksum_macros.svh.
`include "tlv_frame_deframer_checksum_macros.svh"

module tlvd_oreg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlvd_pkg::res_t push_data,
  output logic           full,
  input  logic           out_stall,
  output logic           out_valid,
  output tlvd_pkg::res_t out_data
);
  import tlvd_pkg::*;

  logic head_vld_r, head_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop       = head_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || pop) begin
      if (skid_vld_r) begin
        // Advance the skid word, refill skid from the new result.
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_nxt     = push_data;
        skid_vld_nxt = push;
      end else begin
        head_nxt     = push_data;
        head_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `TLVD_ASSERT_NOW(a_skid_needs_head, clk, rst_n, skid_vld_r, head_vld_r, "skid full, head empty")
  `TLVD_ASSERT_NOW(a_no_push_when_full, clk, rst_n, skid_vld_r, !push, "result pushed while full")
  `TLVD_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_vld_r && pop, head_vld_r, "skid word lost")

endmodule

// File: hdl/tlv_frame_deframer_checksum.sv
// Top level of the TLV frame deframer with two's complement checksum.
// Depends on tlvd_pkg, tlvd_parse and tlvd_oreg.

// Deframer for a byte stream of TLV frames. Each accepted byte is handled in
// the cycle it is accepted, so the block takes one byte per clock when not
// stalled, a rate set by the parser state machine with its 8-bit checksum
// accumulator; a result word (TLV start, value byte, or final frame status)
// is registered in the output register, or the skid register while held.
// A two-entry output stage (output register and skid register) decouples
// the sides: input is stalled only while both entries hold words that the
// receiver has not yet taken. Bytes before the two configured header bytes
// are dropped. The frame is type, 16-bit address (high byte first), code,
// 16-bit parameter length (high byte first), the parameter area walked as
// type/length/value entries, and one checksum byte; all frame bytes,
// checksum included, must sum to zero mod 256. Status reports checksum bad
// first, then malformed TLV, else frame good. TLVs past MAX_TLVS are
// consumed without reports. Write the header registers only while idle.
module tlv_frame_deframer_checksum #(
  parameter int unsigned MAX_TLVS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlvd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  // received byte channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_frame_type,
  output logic [15:0]                    out_device_addr,
  output logic [7:0]                     out_frame_code,
  output logic [15:0]                    out_param_length,
  output logic [3:0]                     out_tlv_index,
  output logic [7:0]                     out_tlv_type,
  output logic [7:0]                     out_tlv_length,
  output logic [7:0]                     out_value_index,
  output logic [7:0]                     out_value_byte
);
  import tlvd_pkg::*;

  logic in_acc;
  logic cfg_we;
  logic res_vld;
  logic full;
  res_t res;
  res_t out_word;

  // Registers are always writable.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Hold input while the result stage has no free entry.
  assign in_stall = full;
  assign in_acc   = in_valid && !in_stall;

  tlvd_parse #(
    .MAX_TLVS(MAX_TLVS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .byte_vld (in_acc),
    .byte_in  (in_byte_in),
    .res_vld  (res_vld),
    .res      (res)
  );

  tlvd_oreg u_oreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_data(res),
    .full     (full),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_word)
  );

  assign out_kind         = out_word.kind;
  assign out_frame_type   = out_word.frame_type;
  assign out_device_addr  = out_word.device_addr;
  assign out_frame_code   = out_word.frame_code;
  assign out_param_length = out_word.param_length;
  assign out_tlv_index    = out_word.tlv_index;
  assign out_tlv_type     = out_word.tlv_type;
  assign out_tlv_length   = out_word.tlv_length;
  assign out_value_index  = out_word.value_index;
  assign out_value_byte   = out_word.value_byte;

endmodule
